// ===== rtl/ioac_pkg.sv =====
// Shared types and constants for the IMU offset averaging calibrator.
package ioac_pkg;

  localparam int SUM_WIDTH = 32;
  localparam int AXES = 6;
  localparam int SAMPLE_W = 16;
  localparam int CNT_W = 16;
  localparam int ZOFF_W = SAMPLE_W + 1;
  localparam int DIV_STEPS = SUM_WIDTH;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int ONE_G = 16384;

  localparam int IN_DATA_W = AXES * SAMPLE_W;
  localparam int OUT_FIELDS_W = (AXES - 1) * SAMPLE_W + ZOFF_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_BUS_ERR   = 2'd2
  } status_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic restart;
    logic start;
    logic abs_step;
    logic div_step;
  } lane_ctl_t;

  typedef struct packed {
    logic    load;
    status_t status;
  } merge_ctl_t;

endpackage

// ===== rtl/imu_offset_average_calibrator_core.sv =====
// Top level: run control, six axis lanes and the result merge stage.
//
// Usage: load sample_count through cfg_wr_en/cfg_wr_data while idle. Send one
// six-axis sample set per transfer on s_axis (tdata: accel x,y,z, gyro x,y,z,
// 16 bits each, lowest first; tuser[0] restart, tuser[1] read failed).
// Results leave on m_axis with the status code in tuser.
// Throughput: a sample that does not end a run is taken without a stall, so
// back-to-back transfers flow at one per cycle, also while a result waits in
// the output register. The sample that ends a run is added, then the six
// lanes divide in parallel, one quotient bit per cycle for 32 bits, and
// s_axis_tready is low until the result has moved into the output register.
// A zero count or a failed read gives an error result through the emit
// state. Reset clears the sums, the sample counter and sample_count, and
// empties the output register. A stalled receiver holds the result; a new
// result waits with s_axis_tready low until the register is free.
module imu_offset_average_calibrator_core
  import ioac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CNT_W-1:0]      cfg_wr_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // restart, read_failed
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // ax_bias, ay_bias, az_bias(17), gx_bias, gy_bias, gz_bias, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]            m_axis_tuser
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ABS,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            sample_count;
  logic [CNT_W-1:0]            taken;
  logic [CNT_W-1:0]            divisor;
  logic [DIV_CNT_W-1:0]        div_cnt;
  status_t                     emit_status;

  logic                        accept;
  logic                        restart;
  logic                        read_failed;
  logic                        count_zero;
  logic [CNT_W-1:0]            taken_base;
  logic [CNT_W-1:0]            taken_next;
  logic                        run_done;
  logic                        out_free;
  lane_ctl_t                   lane_ctl;
  merge_ctl_t                  merge_ctl;
  logic [AXES-1:0][SAMPLE_W-1:0] lane_avg;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign restart       = s_axis_tuser[0];
  assign read_failed   = s_axis_tuser[1];
  assign count_zero    = (sample_count == '0);

  assign taken_base = restart ? '0 : taken;
  assign taken_next = (taken_base == '1) ? taken_base : taken_base + CNT_W'(1);
  assign run_done   = (taken_next >= sample_count);

  always_comb begin
    lane_ctl.clear    = accept && (count_zero || read_failed);
    lane_ctl.add      = accept && !count_zero && !read_failed;
    lane_ctl.restart  = restart;
    lane_ctl.start    = lane_ctl.add && run_done;
    lane_ctl.abs_step = (state == S_ABS);
    lane_ctl.div_step = (state == S_DIV);
    merge_ctl.load    = (state == S_EMIT) && out_free;
    merge_ctl.status  = emit_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (cfg_wr_en) begin
      sample_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      taken       <= '0;
      div_cnt     <= '0;
      emit_status <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (count_zero) begin
              taken       <= '0;
              emit_status <= ST_BAD_COUNT;
              state       <= S_EMIT;
            end else if (read_failed) begin
              taken       <= '0;
              emit_status <= ST_BUS_ERR;
              state       <= S_EMIT;
            end else if (run_done) begin
              taken <= '0;
              state <= S_ABS;
            end else begin
              taken <= taken_next;
            end
          end
        end
        S_ABS: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            div_cnt     <= '0;
            emit_status <= ST_OK;
            state       <= S_EMIT;
          end else begin
            div_cnt <= div_cnt + DIV_CNT_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the run length for the divide.
  always_ff @(posedge clk) begin
    if (lane_ctl.start) begin
      divisor <= taken_next;
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    ioac_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl),
      .sample  (s_axis_tdata[a*SAMPLE_W +: SAMPLE_W]),
      .divisor (divisor),
      .avg     (lane_avg[a])
    );
  end

  ioac_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl           (merge_ctl),
    .lane_avg      (lane_avg),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_zero_count_err: assert property (@(posedge clk) disable iff (rst)
    accept && count_zero |=> state == S_EMIT && emit_status == ST_BAD_COUNT)
    else $error("zero count did not raise bad-count result");

  a_div_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    state != S_DIV |-> div_cnt == '0)
    else $error("divide counter running outside divide");

  a_run_end_divides: assert property (@(posedge clk) disable iff (rst)
    lane_ctl.start |=> state == S_ABS && taken == '0)
    else $error("run end did not start divide");

endmodule

// ===== rtl/ioac_lane.sv =====
// One axis lane: running sum and a bit-serial signed divider by the run length.
module ioac_lane
  import ioac_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  lane_ctl_t           ctl,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [CNT_W-1:0]    divisor,
  output logic [SAMPLE_W-1:0] avg
);

  logic [SUM_WIDTH-1:0] acc;
  logic [SUM_WIDTH-1:0] sum_next;
  logic [SUM_WIDTH-1:0] quo;
  logic [CNT_W-1:0]     rem;
  logic                 neg;
  logic [CNT_W:0]       shifted;
  logic [CNT_W+1:0]     diff;
  logic                 borrow;
  logic [SAMPLE_W-1:0]  mag;

  assign sum_next = (ctl.restart ? '0 : acc)
                  + {{(SUM_WIDTH-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};

  // Restoring division step: one quotient bit a cycle, MSB first.
  assign shifted = {rem, quo[SUM_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign borrow  = diff[CNT_W+1];

  // Magnitude never exceeds 32768, so the low bits carry the whole quotient.
  assign mag = quo[SAMPLE_W-1:0];
  assign avg = neg ? (~mag + SAMPLE_W'(1)) : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.clear || ctl.start) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo <= sum_next;
      neg <= sum_next[SUM_WIDTH-1];
      rem <= '0;
    end else if (ctl.abs_step) begin
      if (neg) begin
        quo <= ~quo + SUM_WIDTH'(1);
      end
    end else if (ctl.div_step) begin
      if (!borrow) begin
        rem <= diff[CNT_W-1:0];
        quo <= {quo[SUM_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[CNT_W-1:0];
        quo <= {quo[SUM_WIDTH-2:0], 1'b0};
      end
    end
  end

  a_start_clears_acc: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> acc == '0)
    else $error("lane accumulator not cleared after run end");

endmodule

// ===== rtl/ioac_merge.sv =====
// Merge stage: gathers the lane averages, applies the 1 g Z correction, holds the result.
module ioac_merge
  import ioac_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  merge_ctl_t                       ctl,
  input  logic [AXES-1:0][SAMPLE_W-1:0]    lane_avg,
  output logic                             out_free,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // ax_bias, ay_bias, az_bias(17), gx_bias, gy_bias, gz_bias, zero pad
  output logic [OUT_DATA_W-1:0]            m_axis_tdata,
  // status
  output logic [1:0]                       m_axis_tuser
);

  logic [ZOFF_W-1:0]       z_off;
  logic [OUT_DATA_W-1:0]   packed_data;

  assign z_off = {lane_avg[2][SAMPLE_W-1], lane_avg[2]} - ZOFF_W'(ONE_G);

  assign packed_data = {
    (OUT_DATA_W - OUT_FIELDS_W)'(0),
    lane_avg[5], lane_avg[4], lane_avg[3],
    z_off,
    lane_avg[1], lane_avg[0]
  };

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Error results carry zero offsets.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      m_axis_tuser <= ctl.status;
      m_axis_tdata <= (ctl.status == ST_OK) ? packed_data : '0;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)
    else $error("error result carries nonzero offsets");

endmodule

// ===== dv/offset_average_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts the calibration results from observed transfers and compares them.
module offset_average_checker
  import ioac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CNT_W-1:0]      cfg_wr_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,
  output int                    outstanding,
  output int                    mismatches
);

  typedef struct {
    status_t               status;
    logic [OUT_DATA_W-1:0] offsets;
  } calib_result_t;

  calib_result_t               expected_results[$];
  logic signed [SUM_WIDTH-1:0] axis_totals[AXES];
  logic [CNT_W-1:0]            sets_taken;
  logic [CNT_W-1:0]            run_length;
  int                          bad_results = 0;

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  // Z offset is one bit wider, so every field above it sits one bit higher.
  function automatic int field_lo(int idx);
    return (idx < 3) ? SAMPLE_W * idx : SAMPLE_W * idx + 1;
  endfunction

  function automatic logic [ZOFF_W-1:0] field_of(logic [OUT_DATA_W-1:0] word, int idx);
    logic [OUT_DATA_W-1:0] shifted;
    shifted = word >> field_lo(idx);
    return (idx == 2) ? shifted[ZOFF_W-1:0] : {1'b0, shifted[SAMPLE_W-1:0]};
  endfunction

  function automatic string field_name(int idx);
    case (idx)
      0: return "ax_bias";
      1: return "ay_bias";
      2: return "az_bias";
      3: return "gx_bias";
      4: return "gy_bias";
      default: return "gz_bias";
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_DATA_W-1:0] exp_val,
                                 input logic [OUT_DATA_W-1:0] act_val);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_val, act_val);
  endtask

  task automatic clear_run();
    int a;
    for (a = 0; a < AXES; a++) axis_totals[a] = '0;
    sets_taken = '0;
  endtask

  task automatic take_sample(input logic [IN_DATA_W-1:0] readings, input logic [1:0] flags);
    calib_result_t     res;
    longint            avg;
    logic [ZOFF_W-1:0] field;
    int                a;
    res.status  = ST_OK;
    res.offsets = '0;
    // zero count beats restart and failed read
    if (run_length == 0) begin
      clear_run();
      res.status = ST_BAD_COUNT;
      expected_results.push_back(res);
      return;
    end
    if (flags[0]) clear_run();
    if (flags[1]) begin
      clear_run();
      res.status = ST_BUS_ERR;
      expected_results.push_back(res);
      return;
    end
    for (a = 0; a < AXES; a++)
      axis_totals[a] = axis_totals[a] +
                       SUM_WIDTH'(longint'($signed(readings[SAMPLE_W*a +: SAMPLE_W])));
    if (sets_taken != '1) sets_taken++;
    // a count lowered mid-run ends the run on the next sample
    if (sets_taken < run_length) return;
    for (a = 0; a < AXES; a++) begin
      avg = longint'(axis_totals[a]) / longint'(sets_taken);
      if (a == 2) avg = avg - ONE_G;
      field = (a == 2) ? avg[ZOFF_W-1:0] : {1'b0, avg[SAMPLE_W-1:0]};
      res.offsets = res.offsets | (OUT_DATA_W'(field) << field_lo(a));
    end
    clear_run();
    expected_results.push_back(res);
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] word, input logic [1:0] code);
    calib_result_t exp_res;
    logic          bad;
    int            f;
    if (expected_results.size() == 0) begin
      bad_results++;
      report_mismatch("result with none pending, data", '0, word);
      return;
    end
    exp_res = expected_results.pop_front();
    bad = 1'b0;
    if (code != exp_res.status) begin
      bad = 1'b1;
      report_mismatch("status", OUT_DATA_W'(exp_res.status), OUT_DATA_W'(code));
    end
    for (f = 0; f < AXES; f++) begin
      if (field_of(word, f) != field_of(exp_res.offsets, f)) begin
        bad = 1'b1;
        report_mismatch(field_name(f), OUT_DATA_W'(field_of(exp_res.offsets, f)),
                        OUT_DATA_W'(field_of(word, f)));
      end
    end
    if (word[OUT_DATA_W-1:OUT_FIELDS_W] != '0) begin
      bad = 1'b1;
      report_mismatch("pad bits", '0, OUT_DATA_W'(word[OUT_DATA_W-1:OUT_FIELDS_W]));
    end
    if (bad) bad_results++;
  endtask

  // Results leave only after their sample is taken, so check before predicting.
  always @(posedge clk) begin
    if (rst) begin
      clear_run();
      run_length = '0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) take_sample(s_axis_tdata, s_axis_tuser);
      if (cfg_wr_en) run_length = cfg_wr_data;
    end
    outstanding <= expected_results.size();
    mismatches  <= bad_results;
  end

endmodule

// ===== dv/imu_offset_average_calibrator_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top: drives sample sets and the count register, and gives the verdict.
module imu_offset_average_calibrator_core_test;
  import ioac_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 480;
  localparam int FULL_SCALE_RUN = 64;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]      cfg_wr_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  int   outstanding;
  int   mismatches;
  int   cycle_count = 0;
  logic sender_burst = 1'b0;
  logic receiver_burst = 1'b0;
  logic hold_request = 1'b0;

  imu_offset_average_calibrator_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  offset_average_checker offset_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .outstanding   (outstanding),
    .mismatches    (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] pick_reading();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] pick_set();
    logic [IN_DATA_W-1:0] set_bits;
    int                   a;
    for (a = 0; a < AXES; a++) set_bits[SAMPLE_W*a +: SAMPLE_W] = pick_reading();
    return set_bits;
  endfunction

  function automatic logic [IN_DATA_W-1:0] sample_set(
    logic [SAMPLE_W-1:0] ax, logic [SAMPLE_W-1:0] ay, logic [SAMPLE_W-1:0] az,
    logic [SAMPLE_W-1:0] gx, logic [SAMPLE_W-1:0] gy, logic [SAMPLE_W-1:0] gz);
    return {gz, gy, gx, az, ay, ax};
  endfunction

  task automatic send_set(input logic restart, input logic read_failed,
                          input logic [IN_DATA_W-1:0] readings);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= readings;
    s_axis_tuser  <= {read_failed, restart};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Let a sample that ends no run settle inside the block before the write.
  task automatic write_count(input logic [CNT_W-1:0] count);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0) receiver_burst = ~receiver_burst;
      gap = receiver_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin : stimulus
    int               sent;
    int               phase_items;
    int               i;
    logic [CNT_W-1:0] count;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // count is zero out of reset; the error wins over both flags
    send_set(1'b1, 1'b1, {AXES{16'h8000}});
    send_set(1'b0, 1'b0, {AXES{16'h7FFF}});

    write_count(16'd2);
    send_set(1'b0, 1'b0, {AXES{16'h7FFF}});
    send_set(1'b0, 1'b0, {AXES{16'h7FFF}});
    send_set(1'b0, 1'b0, {AXES{16'h8000}});
    send_set(1'b0, 1'b0, {AXES{16'h8000}});
    // odd sums of both signs: truncate toward zero
    send_set(1'b0, 1'b0, sample_set(16'h0001, 16'hFFFF, 16'h4001, 16'h0002, 16'hFFFE, 16'h0000));
    send_set(1'b0, 1'b0, sample_set(16'h0002, 16'hFFFE, 16'h4002, 16'h0001, 16'hFFFF, 16'h0001));
    // failed read drops a half-done run
    send_set(1'b0, 1'b0, pick_set());
    send_set(1'b0, 1'b1, pick_set());
    // restart throws away the first sample
    send_set(1'b0, 1'b0, pick_set());
    send_set(1'b1, 1'b0, pick_set());
    send_set(1'b0, 1'b0, pick_set());
    send_set(1'b1, 1'b1, pick_set());

    write_count(16'd1);
    send_set(1'b0, 1'b0, pick_set());
    send_set(1'b0, 1'b0, '0);

    // leave two samples in the run, then lower the count under them
    write_count(16'd3);
    send_set(1'b0, 1'b0, pick_set());
    send_set(1'b0, 1'b0, pick_set());
    write_count(16'd1);
    send_set(1'b0, 1'b0, pick_set());

    // hold the receiver off while samples keep coming, so the input backs up
    hold_request = 1'b1;
    sender_burst = 1'b1;
    for (i = 0; i < 24; i++) send_set(1'b0, 1'b0, pick_set());
    sender_burst = 1'b0;

    // long run, back to back, accel and gyro x readings at full scale
    write_count(CNT_W'(FULL_SCALE_RUN));
    sender_burst = 1'b1;
    for (i = 0; i < FULL_SCALE_RUN; i++)
      send_set(1'b0, 1'b0,
               sample_set(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, pick_reading(), pick_reading()));
    sender_burst = 1'b0;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: count = '0;
        1: count = 16'($urandom_range(9, 40));
        2: count = 16'd1;
        default: count = 16'($urandom_range(2, 8));
      endcase
      write_count(count);
      sender_burst = ($urandom_range(0, 3) == 0);
      phase_items = (count == 0) ? $urandom_range(1, 4) : $urandom_range(10, 50);
      for (i = 0; i < phase_items; i++)
        send_set($urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0, pick_set());
      sent += phase_items;
    end
    sender_burst = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
